FILE: hdl/assert_macros.svh
// Assertion helper macros used by the trainer RTL.
// Each macro expands to one labeled concurrent assertion that reports through $error.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define MBT_ASSERT_IMP(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define MBT_ASSERT_NXT(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/mbt_pkg.sv
// Shared types, constants and arithmetic helpers of the MLP training engine.
// No dependencies; every other file but assert_macros.svh imports this package.
package mbt_pkg;

  localparam int MAX_WEIGHT_LAYERS = 4;
  localparam int MAX_WIDTH         = 16;
  localparam int VALUE_W           = 16;
  localparam int LYR_W             = $clog2(MAX_WEIGHT_LAYERS);
  localparam int NODE_W            = $clog2(MAX_WIDTH);
  localparam int W_AW              = LYR_W + 2 * NODE_W;
  localparam int W_DEPTH           = 1 << W_AW;
  localparam int NODE_AW           = 9;
  localparam int NODE_DEPTH        = 1 << NODE_AW;
  localparam int CFG_IDX_W         = 3;
  localparam int CFG_DATA_W        = 16;
  localparam int REQ_W             = 3;

  // Regions of the node memory.
  localparam logic [NODE_AW-1:0] BIAS_BASE = NODE_AW'(0);
  localparam logic [NODE_AW-1:0] SUM_BASE  = NODE_AW'(MAX_WEIGHT_LAYERS * MAX_WIDTH);
  localparam logic [NODE_AW-1:0] GRAD_BASE = NODE_AW'(2 * MAX_WEIGHT_LAYERS * MAX_WIDTH);
  localparam logic [NODE_AW-1:0] ACT_BASE  = NODE_AW'(3 * MAX_WEIGHT_LAYERS * MAX_WIDTH);
  localparam logic [NODE_AW-1:0] ERR_BASE  =
    NODE_AW'(3 * MAX_WEIGHT_LAYERS * MAX_WIDTH + (MAX_WEIGHT_LAYERS + 1) * MAX_WIDTH);
  localparam int NODE_USED = 3 * MAX_WEIGHT_LAYERS * MAX_WIDTH
                           + 2 * (MAX_WEIGHT_LAYERS + 1) * MAX_WIDTH;

  typedef enum logic [REQ_W-1:0] {
    REQ_WR_WEIGHT  = 3'd0,
    REQ_WR_BIAS    = 3'd1,
    REQ_LOAD_INPUT = 3'd2,
    REQ_TARGET     = 3'd3,
    REQ_CLASSIFY   = 3'd4,
    REQ_RD_WEIGHT  = 3'd5,
    REQ_RD_BIAS    = 3'd6
  } req_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LAYERS = 3'd0,
    CFG_IN_W   = 3'd1,
    CFG_L1_W   = 3'd2,
    CFG_L2_W   = 3'd3,
    CFG_L3_W   = 3'd4,
    CFG_L4_W   = 3'd5,
    CFG_RATE   = 3'd6
  } cfg_t;

  typedef enum logic [5:0] {
    ST_CLEAR, ST_IDLE, ST_RD_ISSUE, ST_RD_OUT,
    ST_F_BIAS, ST_F_BIASD, ST_F_RD, ST_F_MUL, ST_F_ACC, ST_F_SUM, ST_F_T1, ST_F_T2, ST_F_ACT,
    ST_B_ORD, ST_B_OWR,
    ST_G_RDE, ST_G_RDS, ST_G_T0, ST_G_T1, ST_G_T2, ST_G_SQ, ST_G_DER, ST_G_MUL, ST_G_WR,
    ST_E_INIT, ST_E_RD, ST_E_MUL, ST_E_ACC, ST_E_WR,
    ST_U_RDG, ST_U_RDB, ST_U_BMUL, ST_U_BWR, ST_U_RD, ST_U_MUL1, ST_U_MUL2, ST_U_WWR,
    ST_M_RD, ST_M_OUT
  } st_t;

  // Saturate a wide signed value to one data word.
  function automatic logic signed [15:0] sat_v(input logic signed [39:0] v);
    if (v > 40'sd32767) return 16'sh7fff;
    if (v < -40'sd32768) return 16'sh8000;
    return v[15:0];
  endfunction

  // Q3.12 product: round half up at bit 12, then saturate.
  function automatic logic signed [15:0] rnd_q12(input logic signed [32:0] p);
    logic signed [39:0] t;
    t = {{7{p[32]}}, p} + 40'sd2048;
    return sat_v(t >>> 12);
  endfunction

  // Learning-rate product: round half up at bit 16, then saturate.
  function automatic logic signed [15:0] rnd_lr(input logic signed [32:0] p);
    logic signed [39:0] t;
    t = {{7{p[32]}}, p} + 40'sd32768;
    return sat_v(t >>> 16);
  endfunction

  // Saturating difference of two words.
  function automatic logic signed [15:0] sub_sat(input logic signed [15:0] a,
                                                 input logic signed [15:0] b);
    return sat_v({{24{a[15]}}, a} - {{24{b[15]}}, b});
  endfunction

  function automatic logic [2:0] clamp_layers(input logic [2:0] v);
    if (v == 3'd0) return 3'd1;
    if (v > 3'(MAX_WEIGHT_LAYERS)) return 3'(MAX_WEIGHT_LAYERS);
    return v;
  endfunction

  function automatic logic [4:0] clamp_width(input logic [4:0] v);
    if (v == 5'd0) return 5'd1;
    if (v > 5'(MAX_WIDTH)) return 5'(MAX_WIDTH);
    return v;
  endfunction

  function automatic logic [NODE_AW-1:0] node_addr(input logic [NODE_AW-1:0] base,
                                                   input logic [2:0] l,
                                                   input logic [3:0] i);
    return base + {2'b00, l, i};
  endfunction

  // tanh(k/4) in Q12 for k = 0..32; beyond the end it stays at one.
  function automatic logic [12:0] tanh_tab(input logic [5:0] k);
    case (k)
      6'd0:  return 13'd0;
      6'd1:  return 13'd1003;
      6'd2:  return 13'd1893;
      6'd3:  return 13'd2602;
      6'd4:  return 13'd3119;
      6'd5:  return 13'd3475;
      6'd6:  return 13'd3707;
      6'd7:  return 13'd3856;
      6'd8:  return 13'd3949;
      6'd9:  return 13'd4006;
      6'd10: return 13'd4041;
      6'd11: return 13'd4063;
      6'd12: return 13'd4076;
      6'd13: return 13'd4084;
      6'd14: return 13'd4089;
      6'd15: return 13'd4091;
      6'd16: return 13'd4093;
      6'd17: return 13'd4094;
      6'd18: return 13'd4095;
      6'd19: return 13'd4095;
      default: return 13'd4096;
    endcase
  endfunction

endpackage

FILE: hdl/mbt_if.sv
// Valid/ready channel interfaces for request words and result words.
// Depends on mbt_pkg for field widths.
interface mbt_cmd_if;
  import mbt_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [REQ_W-1:0]         req_type;
  logic [LYR_W-1:0]         layer_index;
  logic [NODE_W-1:0]        row_index;
  logic [NODE_W-1:0]        col_index;
  logic signed [VALUE_W-1:0] value;
  logic                     last;
  modport source (output valid, req_type, layer_index, row_index, col_index, value, last,
                  input ready);
  modport sink (input valid, req_type, layer_index, row_index, col_index, value, last,
                output ready);
endinterface

interface mbt_rsp_if;
  import mbt_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [NODE_W-1:0]        out_index;
  logic signed [VALUE_W-1:0] out_value;
  logic                     out_last;
  modport source (output valid, out_index, out_value, out_last, input ready);
  modport sink (input valid, out_index, out_value, out_last, output ready);
endinterface

FILE: hdl/mbt_tanh.sv
// Two-stage tanh unit: table lookup by magnitude, then linear interpolation.
// Depends on mbt_pkg for the tanh table.
module mbt_tanh (
  input  logic                             clk,
  input  logic signed [mbt_pkg::VALUE_W-1:0] x,
  output logic signed [mbt_pkg::VALUE_W-1:0] y
);
  import mbt_pkg::*;

  logic [16:0] mag;
  logic [6:0]  k;
  logic [12:0] tab_a, tab_b;
  logic        s1_neg, s1_top;
  logic [12:0] s1_a, s1_d;
  logic [9:0]  s1_fr;
  logic [22:0] step_prod;
  logic [22:0] step_rnd;
  logic [12:0] t;

  // Stage one: split the magnitude into table index and fraction.
  always_comb begin
    mag   = x[15] ? (17'd0 - {x[15], x}) : {1'b0, x};
    k     = mag[16:10];
    tab_a = tanh_tab(k[5:0]);
    tab_b = tanh_tab(k[5:0] + 6'd1);
  end

  always_ff @(posedge clk) begin
    s1_neg <= x[15];
    s1_top <= (k >= 7'd32);
    s1_a   <= tab_a;
    s1_d   <= tab_b - tab_a;
    s1_fr  <= mag[9:0];
  end

  // Stage two: interpolate between neighbors and restore the sign.
  always_comb begin
    step_prod = 23'(s1_d) * 23'(s1_fr);
    step_rnd  = (step_prod + 23'd512) >> 10;
    t         = s1_top ? 13'd4096 : (s1_a + step_rnd[12:0]);
  end

  always_ff @(posedge clk) begin
    y <= s1_neg ? (16'sd0 - signed'({3'b000, t})) : signed'({3'b000, t});
  end

endmodule

FILE: hdl/mlp_backprop_trainer.sv
// Fully connected tanh network trainer, Q3.12, weights in one RAM, node data in another.
// Loads and writes go to memory when accepted; a read-back word is read in the read-issue state
// and loaded into the result register from the read-out state once that register is free.
// A training step runs the forward pass, output errors, gradients, error propagation and the update.
// Reset is synchronous; a clearing pass then zeroes both memories before the request channel is
// ready. Configuration writes are taken at any time.
`include "assert_macros.svh"

module mlp_backprop_trainer (
  input  logic                              clk,
  input  logic                              rst,
  mbt_cmd_if.sink                           cmd,
  mbt_rsp_if.source                         rsp,
  input  logic                              cfg_wen,
  input  logic [mbt_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mbt_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import mbt_pkg::*;

  st_t state, state_next;

  // Configuration registers.
  logic [2:0]  cfg_layers;
  logic [4:0]  cfg_w [MAX_WEIGHT_LAYERS+1];
  logic [15:0] cfg_lr;

  logic signed [15:0] target [MAX_WIDTH];
  logic [W_AW-1:0] clr_cnt;

  // Sequencer counters and latched request fields.
  logic              train;
  logic [LYR_W-1:0]  lyr;
  logic [NODE_W-1:0] n_cnt, w_cnt;
  logic [LYR_W-1:0]  rq_layer;
  logic [NODE_W-1:0] rq_row, rq_col;
  logic              rq_bias;

  // Datapath registers.
  logic signed [23:0] acc;
  logic signed [32:0] praw;
  logic signed [15:0] g_reg, tmp_e, tmp_d, tmp_b, tmp_w, tanh_x, tanh_y;

  // Memories.
  logic [15:0] wmem [W_DEPTH];
  logic [15:0] nmem [NODE_DEPTH];
  logic [15:0] wq, nq;
  logic              w_we, n_we;
  logic [W_AW-1:0]   w_waddr, w_raddr;
  logic [NODE_AW-1:0] n_waddr, n_raddr;
  logic [15:0]       w_wdata, n_wdata;

  // Output register.
  logic              out_valid;
  logic [3:0]        out_index;
  logic signed [15:0] out_value;
  logic              out_last;
  logic              load_out, out_free;
  logic [3:0]        o_index;
  logic signed [15:0] o_value;
  logic              o_last;

  // Control strobes from the output decoder.
  logic n_clr, n_inc, w_clr, w_inc, lyr_clr, lyr_inc, lyr_dec, lyr_last;

  logic              accept;
  logic [2:0]        nl, lyr3, lyr_p1;
  logic [1:0]        nl_m1;
  logic [4:0]        wcl [MAX_WEIGHT_LAYERS+1];
  logic [4:0]        nin, nout, wlast;
  logic [3:0]        nin_m1, nout_m1, wlast_m1;
  logic              w_end, n_end, o_end, l_end, l_zero;
  logic signed [15:0] mul_a;
  logic signed [16:0] mul_b;
  logic signed [32:0] mul_p;
  logic signed [15:0] p12;
  logic signed [23:0] acc_add;
  logic signed [15:0] acc_sat;
  logic signed [15:0] nq_s, wq_s;

  // Geometry of the layer under work.
  always_comb begin
    for (int i = 0; i <= MAX_WEIGHT_LAYERS; i++) wcl[i] = clamp_width(cfg_w[i]);
    nl       = clamp_layers(cfg_layers);
    nl_m1    = 2'(nl - 3'd1);
    lyr3     = {1'b0, lyr};
    lyr_p1   = lyr3 + 3'd1;
    nin      = wcl[lyr3];
    nout     = wcl[lyr_p1];
    wlast    = wcl[nl];
    nin_m1   = 4'(nin - 5'd1);
    nout_m1  = 4'(nout - 5'd1);
    wlast_m1 = 4'(wlast - 5'd1);
    w_end    = (w_cnt == nin_m1);
    n_end    = (n_cnt == nout_m1);
    o_end    = (n_cnt == wlast_m1);
    l_end    = (lyr == nl_m1);
    l_zero   = (lyr == 2'd0);
  end

  // Shared multiplier and accumulator arithmetic.
  always_comb begin
    nq_s    = signed'(nq);
    wq_s    = signed'(wq);
    mul_p   = mul_a * mul_b;
    p12     = rnd_q12(praw);
    acc_add = acc + {{8{p12[15]}}, p12};
    acc_sat = sat_v({{16{acc[23]}}, acc});
  end

  assign accept    = cmd.valid && cmd.ready;
  assign out_free  = !out_valid || rsp.ready;

  // Next-state decoder.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR:    if (clr_cnt == W_AW'(W_DEPTH - 1)) state_next = ST_IDLE;
      ST_IDLE: begin
        if (accept) begin
          unique case (req_t'(cmd.req_type))
            REQ_TARGET:    if (cmd.last) state_next = ST_F_BIAS;
            REQ_CLASSIFY:  state_next = ST_F_BIAS;
            REQ_RD_WEIGHT, REQ_RD_BIAS: state_next = ST_RD_ISSUE;
            default:       state_next = ST_IDLE;
          endcase
        end
      end
      ST_RD_ISSUE: state_next = ST_RD_OUT;
      ST_RD_OUT:   if (out_free) state_next = ST_IDLE;
      ST_F_BIAS:   state_next = ST_F_BIASD;
      ST_F_BIASD:  state_next = ST_F_RD;
      ST_F_RD:     state_next = ST_F_MUL;
      ST_F_MUL:    state_next = ST_F_ACC;
      ST_F_ACC:    state_next = w_end ? ST_F_SUM : ST_F_RD;
      ST_F_SUM:    state_next = ST_F_T1;
      ST_F_T1:     state_next = ST_F_T2;
      ST_F_T2:     state_next = ST_F_ACT;
      ST_F_ACT: begin
        if (n_end && l_end) state_next = train ? ST_B_ORD : ST_M_RD;
        else state_next = ST_F_BIAS;
      end
      ST_B_ORD:    state_next = ST_B_OWR;
      ST_B_OWR:    state_next = o_end ? ST_G_RDE : ST_B_ORD;
      ST_G_RDE:    state_next = ST_G_RDS;
      ST_G_RDS:    state_next = ST_G_T0;
      ST_G_T0:     state_next = ST_G_T1;
      ST_G_T1:     state_next = ST_G_T2;
      ST_G_T2:     state_next = ST_G_SQ;
      ST_G_SQ:     state_next = ST_G_DER;
      ST_G_DER:    state_next = ST_G_MUL;
      ST_G_MUL:    state_next = ST_G_WR;
      ST_G_WR: begin
        if (!n_end) state_next = ST_G_RDE;
        else if (l_zero) state_next = ST_U_RDG;
        else state_next = ST_E_INIT;
      end
      ST_E_INIT:   state_next = ST_E_RD;
      ST_E_RD:     state_next = ST_E_MUL;
      ST_E_MUL:    state_next = ST_E_ACC;
      ST_E_ACC:    state_next = n_end ? ST_E_WR : ST_E_RD;
      ST_E_WR:     state_next = w_end ? ST_G_RDE : ST_E_INIT;
      ST_U_RDG:    state_next = ST_U_RDB;
      ST_U_RDB:    state_next = ST_U_BMUL;
      ST_U_BMUL:   state_next = ST_U_BWR;
      ST_U_BWR:    state_next = ST_U_RD;
      ST_U_RD:     state_next = ST_U_MUL1;
      ST_U_MUL1:   state_next = ST_U_MUL2;
      ST_U_MUL2:   state_next = ST_U_WWR;
      ST_U_WWR: begin
        if (!w_end) state_next = ST_U_RD;
        else if (!n_end || !l_end) state_next = ST_U_RDG;
        else state_next = ST_M_RD;
      end
      ST_M_RD:     state_next = ST_M_OUT;
      ST_M_OUT:    if (out_free) state_next = o_end ? ST_IDLE : ST_M_RD;
      default:     state_next = ST_IDLE;
    endcase
  end

  // Output decoder: memory ports, multiplier operands and counter strobes.
  always_comb begin
    cmd.ready = 1'b0;
    w_we = 1'b0; w_waddr = '0; w_wdata = '0; w_raddr = '0;
    n_we = 1'b0; n_waddr = '0; n_wdata = '0; n_raddr = '0;
    mul_a = '0; mul_b = '0;
    load_out = 1'b0; o_index = '0; o_value = '0; o_last = 1'b0;
    n_clr = 1'b0; n_inc = 1'b0; w_clr = 1'b0; w_inc = 1'b0;
    lyr_clr = 1'b0; lyr_inc = 1'b0; lyr_dec = 1'b0; lyr_last = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        w_we = 1'b1; w_waddr = clr_cnt;
        n_we = 1'b1; n_waddr = clr_cnt[NODE_AW-1:0];
      end
      ST_IDLE: begin
        cmd.ready = 1'b1;
        if (accept) begin
          unique case (req_t'(cmd.req_type))
            REQ_WR_WEIGHT: begin
              w_we    = 1'b1;
              w_waddr = {cmd.layer_index, cmd.row_index, cmd.col_index};
              w_wdata = cmd.value;
            end
            REQ_WR_BIAS: begin
              n_we    = 1'b1;
              n_waddr = node_addr(BIAS_BASE, {1'b0, cmd.layer_index}, cmd.row_index);
              n_wdata = cmd.value;
            end
            REQ_LOAD_INPUT: begin
              n_we    = 1'b1;
              n_waddr = node_addr(ACT_BASE, 3'd0, cmd.col_index);
              n_wdata = cmd.value;
            end
            REQ_TARGET, REQ_CLASSIFY: begin
              n_clr = 1'b1; lyr_clr = 1'b1;
            end
            default: ;
          endcase
        end
      end
      ST_RD_ISSUE, ST_RD_OUT: begin
        w_raddr = {rq_layer, rq_row, rq_col};
        n_raddr = node_addr(BIAS_BASE, {1'b0, rq_layer}, rq_row);
        if (state == ST_RD_OUT && out_free) begin
          load_out = 1'b1;
          o_value  = rq_bias ? nq_s : wq_s;
          o_last   = 1'b1;
        end
      end
      ST_F_BIAS:  n_raddr = node_addr(BIAS_BASE, lyr3, n_cnt);
      ST_F_BIASD: w_clr = 1'b1;
      ST_F_RD: begin
        w_raddr = {lyr, n_cnt, w_cnt};
        n_raddr = node_addr(ACT_BASE, lyr3, w_cnt);
      end
      ST_F_MUL: begin
        mul_a = wq_s; mul_b = {nq_s[15], nq_s};
      end
      ST_F_ACC: if (!w_end) w_inc = 1'b1;
      ST_F_SUM: begin
        n_we = 1'b1; n_waddr = node_addr(SUM_BASE, lyr3, n_cnt); n_wdata = acc_sat;
      end
      ST_F_ACT: begin
        n_we = 1'b1; n_waddr = node_addr(ACT_BASE, lyr_p1, n_cnt); n_wdata = tanh_y;
        if (n_end) begin
          n_clr = 1'b1;
          if (!l_end) lyr_inc = 1'b1;
        end else begin
          n_inc = 1'b1;
        end
      end
      ST_B_ORD: n_raddr = node_addr(ACT_BASE, nl, n_cnt);
      ST_B_OWR: begin
        n_we = 1'b1; n_waddr = node_addr(ERR_BASE, nl, n_cnt);
        n_wdata = sub_sat(nq_s, target[n_cnt]);
        if (o_end) begin
          n_clr = 1'b1; lyr_last = 1'b1;
        end else begin
          n_inc = 1'b1;
        end
      end
      ST_G_RDE: n_raddr = node_addr(ERR_BASE, lyr_p1, n_cnt);
      ST_G_RDS: n_raddr = node_addr(SUM_BASE, lyr3, n_cnt);
      ST_G_SQ: begin
        mul_a = tanh_y; mul_b = {tanh_y[15], tanh_y};
      end
      ST_G_MUL: begin
        mul_a = tmp_e; mul_b = {tmp_d[15], tmp_d};
      end
      ST_G_WR: begin
        n_we = 1'b1; n_waddr = node_addr(GRAD_BASE, lyr3, n_cnt); n_wdata = p12;
        if (n_end) begin
          n_clr = 1'b1; w_clr = 1'b1;
        end else begin
          n_inc = 1'b1;
        end
      end
      ST_E_INIT: n_clr = 1'b1;
      ST_E_RD: begin
        w_raddr = {lyr, n_cnt, w_cnt};
        n_raddr = node_addr(GRAD_BASE, lyr3, n_cnt);
      end
      ST_E_MUL: begin
        mul_a = wq_s; mul_b = {nq_s[15], nq_s};
      end
      ST_E_ACC: if (!n_end) n_inc = 1'b1;
      ST_E_WR: begin
        n_we = 1'b1; n_waddr = node_addr(ERR_BASE, lyr3, w_cnt); n_wdata = acc_sat;
        if (w_end) begin
          lyr_dec = 1'b1; n_clr = 1'b1;
        end else begin
          w_inc = 1'b1;
        end
      end
      ST_U_RDG: n_raddr = node_addr(GRAD_BASE, lyr3, n_cnt);
      ST_U_RDB: n_raddr = node_addr(BIAS_BASE, lyr3, n_cnt);
      ST_U_BMUL: begin
        mul_a = g_reg; mul_b = {1'b0, cfg_lr};
      end
      ST_U_BWR: begin
        n_we = 1'b1; n_waddr = node_addr(BIAS_BASE, lyr3, n_cnt);
        n_wdata = sub_sat(tmp_b, rnd_lr(praw));
        w_clr = 1'b1;
      end
      ST_U_RD: begin
        w_raddr = {lyr, n_cnt, w_cnt};
        n_raddr = node_addr(ACT_BASE, lyr3, w_cnt);
      end
      ST_U_MUL1: begin
        mul_a = g_reg; mul_b = {nq_s[15], nq_s};
      end
      ST_U_MUL2: begin
        mul_a = p12; mul_b = {1'b0, cfg_lr};
      end
      ST_U_WWR: begin
        w_we = 1'b1; w_waddr = {lyr, n_cnt, w_cnt};
        w_wdata = sub_sat(tmp_w, rnd_lr(praw));
        if (w_end) begin
          if (n_end) begin
            n_clr = 1'b1;
            if (!l_end) lyr_inc = 1'b1;
          end else begin
            n_inc = 1'b1;
          end
        end else begin
          w_inc = 1'b1;
        end
      end
      ST_M_RD: n_raddr = node_addr(ACT_BASE, nl, n_cnt);
      ST_M_OUT: begin
        n_raddr = node_addr(ACT_BASE, nl, n_cnt);
        if (out_free) begin
          load_out = 1'b1;
          o_index  = n_cnt;
          o_value  = nq_s;
          o_last   = o_end;
          if (!o_end) n_inc = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // State, configuration, targets and clearing counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      clr_cnt    <= '0;
      cfg_layers <= 3'd2;
      for (int i = 0; i <= MAX_WEIGHT_LAYERS; i++) cfg_w[i] <= 5'd16;
      cfg_lr     <= 16'd655;
      for (int i = 0; i < MAX_WIDTH; i++) target[i] <= '0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) clr_cnt <= clr_cnt + W_AW'(1);
      if (cfg_wen) begin
        unique case (cfg_t'(cfg_index))
          CFG_LAYERS: cfg_layers <= cfg_data[2:0];
          CFG_IN_W:   cfg_w[0] <= cfg_data[4:0];
          CFG_L1_W:   cfg_w[1] <= cfg_data[4:0];
          CFG_L2_W:   cfg_w[2] <= cfg_data[4:0];
          CFG_L3_W:   cfg_w[3] <= cfg_data[4:0];
          CFG_L4_W:   cfg_w[4] <= cfg_data[4:0];
          CFG_RATE:   cfg_lr <= cfg_data;
          default: ;
        endcase
      end
      if (accept && req_t'(cmd.req_type) == REQ_TARGET) target[cmd.col_index] <= cmd.value;
      if (load_out) out_valid <= 1'b1;
      else if (rsp.ready) out_valid <= 1'b0;
    end
  end

  // Counters, latched request fields and datapath registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      train    <= (req_t'(cmd.req_type) == REQ_TARGET);
      rq_layer <= cmd.layer_index;
      rq_row   <= cmd.row_index;
      rq_col   <= cmd.col_index;
      rq_bias  <= (req_t'(cmd.req_type) == REQ_RD_BIAS);
    end
    if (n_clr) n_cnt <= '0;
    else if (n_inc) n_cnt <= n_cnt + 4'd1;
    if (w_clr) w_cnt <= '0;
    else if (w_inc) w_cnt <= w_cnt + 4'd1;
    if (lyr_clr) lyr <= '0;
    else if (lyr_inc) lyr <= lyr + 2'd1;
    else if (lyr_dec) lyr <= lyr - 2'd1;
    else if (lyr_last) lyr <= nl_m1;

    praw <= mul_p;
    unique case (state)
      ST_F_BIASD:        acc <= {{8{nq_s[15]}}, nq_s};
      ST_F_ACC, ST_E_ACC: acc <= acc_add;
      ST_E_INIT:         acc <= '0;
      default: ;
    endcase
    if (state == ST_F_SUM) tanh_x <= acc_sat;
    if (state == ST_G_T0)  tanh_x <= nq_s;
    if (state == ST_G_RDS) tmp_e <= nq_s;
    if (state == ST_G_DER) tmp_d <= sub_sat(16'sd4096, p12);
    if (state == ST_U_RDB) g_reg <= nq_s;
    if (state == ST_U_BMUL) tmp_b <= nq_s;
    if (state == ST_U_MUL1) tmp_w <= wq_s;
    if (load_out) begin
      out_index <= o_index;
      out_value <= o_value;
      out_last  <= o_last;
    end
  end

  // Weight memory: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (w_we) wmem[w_waddr] <= w_wdata;
    wq <= wmem[w_raddr];
  end

  // Node memory: biases, sums, gradients, activations and errors.
  always_ff @(posedge clk) begin
    if (n_we) nmem[n_waddr] <= n_wdata;
    nq <= nmem[n_raddr];
  end

  mbt_tanh u_tanh (
    .clk (clk),
    .x   (tanh_x),
    .y   (tanh_y)
  );

  assign rsp.valid     = out_valid;
  assign rsp.out_index = out_index;
  assign rsp.out_value = out_value;
  assign rsp.out_last  = out_last;

  // Checks on the sequencer.
  `MBT_ASSERT_IMP(a_out_free, clk, rst, load_out, (!out_valid || rsp.ready), "result word overwritten")
  `MBT_ASSERT_IMP(a_clear_blocks, clk, rst, state == ST_CLEAR, !cmd.ready, "request taken while clearing")
  `MBT_ASSERT_IMP(a_node_range, clk, rst, n_we && state != ST_CLEAR, n_waddr < NODE_AW'(NODE_USED), "node write outside regions")
  `MBT_ASSERT_NXT(a_acc_start, clk, rst, state == ST_E_INIT, acc == 24'sd0, "error accumulator not cleared")

endmodule

FILE: test/mlp_backprop_trainer_test.sv
// Self-checking testbench for the MLP training engine: directed and random request words,
// a bit-exact fixed-point network predictor, and a result checker.
// Depends on mbt_pkg, the mbt_cmd_if/mbt_rsp_if interfaces and mlp_backprop_trainer.
`timescale 1ns / 100ps

module mlp_backprop_trainer_test;
  import mbt_pkg::*;

  typedef struct {
    logic [2:0]  req;
    logic [1:0]  layer;
    logic [3:0]  row;
    logic [3:0]  col;
    logic [15:0] value;
    logic        last;
  } cmd_word_t;

  typedef struct {
    logic [3:0]  idx;
    logic [15:0] val;
    logic        last;
  } rsp_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wen = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  mbt_cmd_if cmd ();
  mbt_rsp_if rsp ();

  mlp_backprop_trainer u_dut (
    .clk(clk), .rst(rst), .cmd(cmd.sink), .rsp(rsp.source),
    .cfg_wen(cfg_wen), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Network state as the predictor sees it.
  int wgt [4][16][16];
  int bia [4][16];
  int sums [4][16];
  int acts [5][16];
  int errs [5][16];
  int grads [4][16];
  int tgts [16];
  int unsigned n_layers_reg, rate_reg;
  int unsigned width_reg [5];

  cmd_word_t pending_words[$];
  rsp_word_t exp_words[$];
  int mismatches = 0;
  bit long_hold_req = 1'b0;

  function automatic int sat16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return int'(v);
  endfunction

  // Product with rounding half up at bit 12, then saturation.
  function automatic int qmul(longint a, longint b);
    return sat16((a * b + 2048) >>> 12);
  endfunction

  function automatic int rate_scale(longint g);
    return sat16((g * longint'(rate_reg) + 32768) >>> 16);
  endfunction

  function automatic longint tanh_point(int k);
    int pts [33] = '{0, 1003, 1893, 2602, 3119, 3475, 3707, 3856, 3949, 4006, 4041,
                     4063, 4076, 4084, 4089, 4091, 4093, 4094, 4095, 4095, 4096, 4096,
                     4096, 4096, 4096, 4096, 4096, 4096, 4096, 4096, 4096, 4096, 4096};
    return pts[k];
  endfunction

  // Table tanh with linear interpolation over quarter steps.
  function automatic int tanh_q(int x);
    longint mag, k, fr, t, a, b;
    mag = (x < 0) ? -longint'(x) : longint'(x);
    k = mag >>> 10;
    fr = mag & 1023;
    if (k >= 32) t = 4096;
    else begin
      a = tanh_point(int'(k));
      b = tanh_point(int'(k) + 1);
      t = a + (((b - a) * fr + 512) >>> 10);
    end
    return sat16((x < 0) ? -t : t);
  endfunction

  function automatic int sech2_q(int x);
    longint th;
    th = tanh_q(x);
    return sat16(4096 - ((th * th + 2048) >>> 12));
  endfunction

  function automatic int node_count(int k);
    int unsigned w;
    w = width_reg[k];
    if (w < 1) w = 1;
    if (w > 16) w = 16;
    return int'(w);
  endfunction

  function automatic int layer_count();
    if (n_layers_reg < 1) return 1;
    if (n_layers_reg > 4) return 4;
    return int'(n_layers_reg);
  endfunction

  function automatic void run_forward();
    longint acc;
    for (int l = 0; l < layer_count(); l++)
      for (int n = 0; n < node_count(l + 1); n++) begin
        acc = bia[l][n];
        for (int w = 0; w < node_count(l); w++) acc += qmul(wgt[l][n][w], acts[l][w]);
        sums[l][n] = sat16(acc);
        acts[l + 1][n] = tanh_q(sums[l][n]);
      end
  endfunction

  function automatic void run_backward();
    int nl;
    int g;
    longint acc [16];
    nl = layer_count();
    for (int i = 0; i < node_count(nl); i++)
      errs[nl][i] = sat16(longint'(acts[nl][i]) - tgts[i]);
    for (int l = nl - 1; l >= 0; l--) begin
      foreach (acc[w]) acc[w] = 0;
      for (int n = 0; n < node_count(l + 1); n++) begin
        g = qmul(errs[l + 1][n], sech2_q(sums[l][n]));
        grads[l][n] = g;
        for (int w = 0; w < node_count(l); w++) acc[w] += qmul(g, wgt[l][n][w]);
      end
      for (int w = 0; w < node_count(l); w++) errs[l][w] = sat16(acc[w]);
    end
  endfunction

  function automatic void run_update();
    int g;
    for (int l = 0; l < layer_count(); l++)
      for (int n = 0; n < node_count(l + 1); n++) begin
        g = grads[l][n];
        bia[l][n] = sat16(longint'(bia[l][n]) - rate_scale(g));
        for (int w = 0; w < node_count(l); w++)
          wgt[l][n][w] = sat16(longint'(wgt[l][n][w]) - rate_scale(qmul(g, acts[l][w])));
      end
  endfunction

  function automatic void push_outputs();
    int n;
    rsp_word_t r;
    n = node_count(layer_count());
    for (int i = 0; i < n; i++) begin
      r = '{4'(i), 16'(acts[layer_count()][i]), i == n - 1};
      exp_words.insert(exp_words.size(), r);
    end
  endfunction

  function automatic void push_word(int w);
    rsp_word_t r;
    r = '{4'd0, 16'(w), 1'b1};
    exp_words.insert(exp_words.size(), r);
  endfunction

  // Apply one accepted request word to the predicted network.
  function automatic void predict_request(cmd_word_t c);
    int v;
    v = int'($signed(c.value));
    case (c.req)
      REQ_WR_WEIGHT:  wgt[c.layer][c.row][c.col] = v;
      REQ_WR_BIAS:    bia[c.layer][c.row] = v;
      REQ_LOAD_INPUT: acts[0][c.col] = v;
      REQ_TARGET: begin
        tgts[c.col] = v;
        if (c.last) begin
          run_forward();
          run_backward();
          push_outputs();
          run_update();
        end
      end
      REQ_CLASSIFY: begin
        run_forward();
        push_outputs();
      end
      REQ_RD_WEIGHT:  push_word(wgt[c.layer][c.row][c.col]);
      REQ_RD_BIAS:    push_word(bia[c.layer][c.row]);
      default: ;
    endcase
  endfunction

  // Driver: bursts of words separated by random gaps.
  int burst_left = 4;
  int gap_left = 0;
  always @(posedge clk) begin
    if (rst) begin
      cmd.valid <= 1'b0;
      cmd.req_type <= '0;
      cmd.layer_index <= '0;
      cmd.row_index <= '0;
      cmd.col_index <= '0;
      cmd.value <= '0;
      cmd.last <= 1'b0;
    end else begin
      if (cmd.valid && cmd.ready) begin
        predict_request(pending_words.pop_front());
      end
      if (!cmd.valid || cmd.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          cmd.valid <= 1'b0;
        end else if (pending_words.size() > 0) begin
          cmd.valid <= 1'b1;
          cmd.req_type <= pending_words[0].req;
          cmd.layer_index <= pending_words[0].layer;
          cmd.row_index <= pending_words[0].row;
          cmd.col_index <= pending_words[0].col;
          cmd.value <= pending_words[0].value;
          cmd.last <= pending_words[0].last;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 12);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
          end
        end else begin
          cmd.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: a randomly drawn stall mode sets how often ready is held low; one long hold when requested.
  int hold_cnt = 0;
  int cyc = 0;
  int stall_mode = 0;
  always @(posedge clk) begin
    cyc++;
    if (cyc % 64 == 0) stall_mode = $urandom_range(0, 2);
    if (rst) begin
      rsp.ready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt--;
      rsp.ready <= 1'b0;
    end else if (long_hold_req) begin
      long_hold_req = 1'b0;
      hold_cnt = 600;
      rsp.ready <= 1'b0;
    end else begin
      case (stall_mode)
        0: rsp.ready <= 1'b1;
        1: rsp.ready <= $urandom_range(0, 1);
        default: rsp.ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // Monitor: every accepted result word against the oldest expectation.
  always @(posedge clk) begin
    rsp_word_t e;
    if (!rst && rsp.valid && rsp.ready) begin
      if (exp_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result word: index %0d value %h last %b",
                   rsp.out_index, rsp.out_value, rsp.out_last);
      end else begin
        e = exp_words.pop_front();
        if (rsp.out_index !== e.idx || rsp.out_value !== e.val || rsp.out_last !== e.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: expected index %0d value %h last %b, got %0d %h %b",
                     e.idx, e.val, e.last, rsp.out_index, rsp.out_value, rsp.out_last);
        end
      end
    end
  end

  function automatic logic [15:0] rand_value();
    if ($urandom_range(0, 2) == 0) return 16'($urandom);
    return 16'(int'($urandom_range(0, 16384)) - 8192);
  endfunction

  function automatic void add_word(logic [2:0] req, int layer, int row, int col,
                                   logic [15:0] value, logic last);
    cmd_word_t c;
    c = '{req, 2'(layer), 4'(row), 4'(col), value, last};
    pending_words.insert(pending_words.size(), c);
  endfunction

  task automatic cfg_write(cfg_t idx, int unsigned data);
    @(posedge clk);
    cfg_wen <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_DATA_W'(data);
    if (idx == CFG_LAYERS) n_layers_reg = data & 7;
    else if (idx == CFG_RATE) rate_reg = data & 16'hffff;
    else width_reg[int'(idx) - int'(CFG_IN_W)] = data & 31;
    @(posedge clk);
    cfg_wen <= 1'b0;
  endtask

  // Wait until every queued word is taken and every result has come back.
  task automatic drain();
    while (pending_words.size() > 0 || cmd.valid || exp_words.size() > 0)
      @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  // Mostly training samples and classifies for the current shape, plus loads,
  // read-backs and noise.
  task automatic fill_random(int n_words);
    int made, pick, nl;
    made = 0;
    while (made < n_words) begin
      nl = layer_count();
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        for (int i = 0; i < node_count(0); i++)
          if ($urandom_range(0, 3) != 0) begin
            add_word(REQ_LOAD_INPUT, 0, 0, i, rand_value(), 1'($urandom));
            made++;
          end
        for (int i = 0; i < node_count(nl); i++)
          if ($urandom_range(0, 2) != 0) begin
            add_word(REQ_TARGET, 0, 0, i, rand_value(), 1'b0);
            made++;
          end
        add_word(REQ_TARGET, $urandom, $urandom, $urandom_range(0, node_count(nl) - 1),
                 rand_value(), 1'b1);
        made++;
      end else if (pick < 55) begin
        add_word(REQ_CLASSIFY, $urandom, $urandom, $urandom, $urandom, 1'($urandom));
        made++;
      end else if (pick < 72) begin
        add_word(($urandom_range(0, 1) == 0) ? REQ_WR_WEIGHT : REQ_WR_BIAS,
                 $urandom_range(0, nl - 1), $urandom, $urandom, rand_value(), 1'($urandom));
        made++;
      end else if (pick < 90) begin
        add_word(($urandom_range(0, 1) == 0) ? REQ_RD_WEIGHT : REQ_RD_BIAS,
                 $urandom, $urandom, $urandom, $urandom, 1'($urandom));
        made++;
      end else begin
        add_word(3'd7, $urandom, $urandom, $urandom, $urandom, 1'($urandom));
      end
    end
  endtask

  initial begin
    n_layers_reg = 2;
    rate_reg = 655;
    foreach (width_reg[i]) width_reg[i] = 16;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed: address and value extremes, every request kind, ignored fields.
    add_word(REQ_RD_WEIGHT, 3, 15, 15, 16'h1234, 1'b1);
    add_word(REQ_RD_BIAS, 0, 0, 9, 16'h0000, 1'b0);
    add_word(REQ_WR_WEIGHT, 3, 15, 15, 16'h7fff, 1'b1);
    add_word(REQ_WR_WEIGHT, 0, 0, 0, 16'h8000, 1'b0);
    add_word(REQ_WR_BIAS, 3, 15, 7, 16'h8000, 1'b0);
    add_word(REQ_WR_BIAS, 0, 0, 0, 16'h7fff, 1'b1);
    add_word(REQ_RD_WEIGHT, 3, 15, 15, 16'h0, 1'b0);
    add_word(REQ_RD_WEIGHT, 0, 0, 0, 16'hffff, 1'b1);
    add_word(REQ_RD_BIAS, 3, 15, 0, 16'h0, 1'b0);
    add_word(REQ_RD_BIAS, 0, 0, 15, 16'h0, 1'b0);
    add_word(REQ_LOAD_INPUT, 0, 0, 0, 16'h7fff, 1'b1);
    add_word(REQ_LOAD_INPUT, 3, 15, 15, 16'h8000, 1'b0);
    add_word(REQ_WR_WEIGHT, 0, 1, 15, 16'h1000, 1'b0);
    add_word(REQ_WR_WEIGHT, 1, 0, 1, 16'hf000, 1'b0);
    add_word(REQ_TARGET, 0, 0, 15, 16'h8000, 1'b0);
    add_word(REQ_TARGET, 0, 0, 0, 16'h7fff, 1'b1);
    add_word(REQ_CLASSIFY, 3, 15, 15, 16'hffff, 1'b1);
    add_word(3'd7, 3, 15, 15, 16'hffff, 1'b1);
    add_word(REQ_RD_WEIGHT, 1, 0, 1, 16'h0, 1'b0);
    add_word(REQ_RD_BIAS, 1, 0, 0, 16'h0, 1'b0);
    drain();

    // Random phases over shapes and rates; small shapes mostly, extremes included.
    for (int ph = 0; ph < 10; ph++) begin
      case (ph)
        0: begin
          cfg_write(CFG_LAYERS, 0);
          cfg_write(CFG_IN_W, 0);
          cfg_write(CFG_L1_W, 1);
          cfg_write(CFG_RATE, 65535);
        end
        1: begin
          cfg_write(CFG_LAYERS, 7);
          cfg_write(CFG_IN_W, 31);
          cfg_write(CFG_L1_W, 16);
          cfg_write(CFG_L2_W, 17);
          cfg_write(CFG_L3_W, 16);
          cfg_write(CFG_L4_W, 31);
          cfg_write(CFG_RATE, 0);
        end
        default: begin
          cfg_write(CFG_LAYERS, $urandom_range(0, 7));
          cfg_write(CFG_IN_W, $urandom_range(0, 5));
          cfg_write(CFG_L1_W, $urandom_range(0, 5));
          cfg_write(CFG_L2_W, $urandom_range(1, 5));
          cfg_write(CFG_L3_W, $urandom_range(1, 4));
          cfg_write(CFG_L4_W, ($urandom_range(0, 3) == 0) ? $urandom_range(16, 31)
                                                           : $urandom_range(1, 4));
          cfg_write(CFG_RATE, $urandom);
        end
      endcase
      if (ph == 3) long_hold_req = 1'b1;
      fill_random((ph == 1) ? 6 : 23);
      drain();
    end

    if (mismatches == 0 && exp_words.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #300_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
